@@ rtl/core/pund_pkg.sv @@
// Package for the packed 16-bit file-name decoder.
// Holds widths, limits, command codes and state types; no dependencies.
`default_nettype none

package pund_pkg;

    // Decoded name limit and stored plain-name depth
    localparam int MAX_NAME    = 32;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CHAR_W = 16;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 6;
    localparam int PAIR_W = 3;
    localparam int RUN_W  = 8;

    localparam logic [POS_W-1:0]  POS_LIMIT  = POS_W'(MAX_NAME);
    localparam logic [POS_W-1:0]  TERM_POS   = POS_W'(MAX_NAME - 1);
    localparam logic [CNT_W-1:0]  STORE_FULL = CNT_W'(STORE_DEPTH);
    localparam logic [PAIR_W-1:0] FLAG_PAIRS = 3'd4;
    localparam logic [RUN_W-1:0]  RUN_BIAS   = 8'd2;

    // Mode of an input word
    localparam logic MODE_PLAIN  = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    // Two-bit commands from the flag byte
    localparam logic [1:0] CMD_LOW  = 2'd0;
    localparam logic [1:0] CMD_HIGH = 2'd1;
    localparam logic [1:0] CMD_FULL = 2'd2;
    localparam logic [1:0] CMD_RUN  = 2'd3;

    // Stream parse phase
    typedef enum logic [1:0] {
        PH_HIGH,
        PH_CMD,
        PH_HI2,
        PH_CORR
    } t_phase;

    // Output sequencer state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_RUN_RD,
        ST_RUN_EM,
        ST_TERM
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/pund_if.sv @@
// Valid/ready channel interfaces for the packed name decoder.
// Depends on pund_pkg for field widths.
`default_nettype none

interface pund_in_if;
    import pund_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;

    modport source (output valid, output mode, output data_byte, output stream_end,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input stream_end,
                    output ready);
endinterface

interface pund_out_if;
    import pund_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_value;
    logic [POS_W-1:0]  char_index;
    logic              last;

    modport source (output valid, output char_value, output char_index, output last,
                    input ready);
    modport sink   (input valid, input char_value, input char_index, input last,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/pund_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
`default_nettype none

module pund_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/packed_unicode_name_decoder.sv @@
// Top level of the packed 16-bit file-name decoder: stream parser, run sequencer
// and output register. Depends on pund_pkg, pund_if.sv and pund_ram.
//
//   channel  dir  fields                            accepted when
//   i_in     in   mode, data_byte, stream_end       valid && ready
//   o_out    out  char_value, char_index, last      valid && ready
//
// A plain word is written to the name RAM when accepted, unless the RAM is full.
// A stream word is parsed when accepted, then the sequencer emits each character or
// terminator it yields; a run yields one character per cycle out of the RAM while
// the output is not stalled, after the read of its first byte in ST_RUN_RD.
// Reset (i_rst_n low, synchronous) clears parse and sequencer state, not the payload.
// A stalled output holds the sequencer; input is taken only while it is idle.
`default_nettype none

module packed_unicode_name_decoder (
    input wire logic i_clk,
    input wire logic i_rst_n,
    pund_in_if.sink  i_in,
    pund_out_if.source o_out
);
    import pund_pkg::*;

    // Control and parse state
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_plain_count, n_plain_count;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic [BYTE_W-1:0]  r_high, n_high;
    logic [BYTE_W-1:0]  r_flag, n_flag;
    logic [PAIR_W-1:0]  r_pairs, n_pairs;
    logic [BYTE_W-1:0]  r_held, n_held;
    logic               r_end, n_end;

    // Pending work payload
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [RUN_W-1:0]   r_run_cnt, n_run_cnt;
    logic               r_run_corr, n_run_corr;
    logic [BYTE_W-1:0]  r_corr, n_corr;

    // Output register
    logic               r_o_valid, n_o_valid;
    logic [CHAR_W-1:0]  r_o_char, n_o_char;
    logic [POS_W-1:0]   r_o_idx, n_o_idx;
    logic               r_o_last, n_o_last;

    // RAM ports and helpers
    logic                ram_we;
    logic [STORE_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                accept;
    logic                slot_free;
    logic [BYTE_W-1:0]   stored;
    logic [BYTE_W-1:0]   corr_sum;
    logic [POS_W-1:0]    pos_inc;
    logic [RUN_W-1:0]    cnt_dec;
    logic [BYTE_W-1:0]   b;

    assign accept    = i_in.valid && i_in.ready;
    assign slot_free = !r_o_valid || o_out.ready;
    assign b         = i_in.data_byte;
    assign pos_inc   = r_out_pos + POS_W'(1);
    assign cnt_dec   = r_run_cnt - RUN_W'(1);
    assign ram_we    = accept && (i_in.mode == MODE_PLAIN) && (r_plain_count < STORE_FULL);

    // Present the next run address while emitting, else hold the current one
    assign ram_raddr = (r_state == ST_RUN_EM && slot_free) ? pos_inc[STORE_AW-1:0]
                                                           : r_out_pos[STORE_AW-1:0];

    // Reads past the loaded name give zero
    assign stored   = (r_out_pos < r_plain_count) ? ram_rdata : '0;
    assign corr_sum = BYTE_W'(stored + r_corr);

    pund_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_plain_count[STORE_AW-1:0]),
        .i_wdata (b),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state, parsing and emission
    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_plain_count = r_plain_count;
        n_out_pos     = r_out_pos;
        n_high        = r_high;
        n_flag        = r_flag;
        n_pairs       = r_pairs;
        n_held        = r_held;
        n_end         = r_end;
        n_char        = r_char;
        n_run_cnt     = r_run_cnt;
        n_run_corr    = r_run_corr;
        n_corr        = r_corr;
        n_o_valid     = o_out.ready ? 1'b0 : r_o_valid;
        n_o_char      = r_o_char;
        n_o_idx       = r_o_idx;
        n_o_last      = r_o_last;

        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.mode == MODE_PLAIN) begin
                    if (r_plain_count < STORE_FULL) begin
                        n_plain_count = r_plain_count + CNT_W'(1);
                    end
                end else if (accept) begin
                    n_end   = i_in.stream_end;
                    n_state = i_in.stream_end ? ST_TERM : ST_IDLE;
                    case (r_phase)
                        PH_HIGH: begin
                            n_high  = b;
                            n_phase = PH_CMD;
                        end
                        PH_CMD: begin
                            if (r_out_pos >= POS_LIMIT) begin
                                // ignore bytes once the limit is reached
                            end else if (r_pairs == '0) begin
                                n_flag  = b;
                                n_pairs = FLAG_PAIRS;
                            end else begin
                                case (r_flag[7:6])
                                    CMD_LOW: begin
                                        n_char  = {{BYTE_W{1'b0}}, b};
                                        n_state = ST_CHAR;
                                        n_flag  = {r_flag[5:0], 2'b00};
                                        n_pairs = r_pairs - PAIR_W'(1);
                                    end
                                    CMD_HIGH: begin
                                        n_char  = {r_high, b};
                                        n_state = ST_CHAR;
                                        n_flag  = {r_flag[5:0], 2'b00};
                                        n_pairs = r_pairs - PAIR_W'(1);
                                    end
                                    CMD_FULL: begin
                                        n_held  = b;
                                        n_phase = PH_HI2;
                                    end
                                    CMD_RUN: begin
                                        if (b[7]) begin
                                            n_held  = b;
                                            n_phase = PH_CORR;
                                        end else begin
                                            n_run_cnt  = {1'b0, b[6:0]} + RUN_BIAS;
                                            n_run_corr = 1'b0;
                                            n_state    = ST_RUN_RD;
                                            n_flag     = {r_flag[5:0], 2'b00};
                                            n_pairs    = r_pairs - PAIR_W'(1);
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                        PH_HI2: begin
                            n_char  = {b, r_held};
                            n_state = ST_CHAR;
                            n_flag  = {r_flag[5:0], 2'b00};
                            n_pairs = r_pairs - PAIR_W'(1);
                            n_phase = PH_CMD;
                        end
                        PH_CORR: begin
                            n_run_cnt  = {1'b0, r_held[6:0]} + RUN_BIAS;
                            n_run_corr = 1'b1;
                            n_corr     = b;
                            n_state    = ST_RUN_RD;
                            n_flag     = {r_flag[5:0], 2'b00};
                            n_pairs    = r_pairs - PAIR_W'(1);
                            n_phase    = PH_CMD;
                        end
                        default: begin
                            n_phase = PH_HIGH;
                        end
                    endcase
                end
            end
            ST_CHAR: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = r_char;
                    n_o_idx   = r_out_pos;
                    n_o_last  = 1'b0;
                    n_out_pos = pos_inc;
                    n_state   = r_end ? ST_TERM : ST_IDLE;
                end
            end
            ST_RUN_RD: begin
                // RAM address for the first run byte is presented here
                n_state = ST_RUN_EM;
            end
            ST_RUN_EM: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = r_run_corr ? {r_high, corr_sum} : {{BYTE_W{1'b0}}, stored};
                    n_o_idx   = r_out_pos;
                    n_o_last  = 1'b0;
                    n_out_pos = pos_inc;
                    n_run_cnt = cnt_dec;
                    if (cnt_dec == '0 || pos_inc >= POS_LIMIT) begin
                        n_state = r_end ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    n_o_valid     = 1'b1;
                    n_o_char      = '0;
                    n_o_idx       = (r_out_pos < POS_LIMIT) ? r_out_pos : TERM_POS;
                    n_o_last      = 1'b1;
                    // restart for the next name
                    n_plain_count = '0;
                    n_out_pos     = '0;
                    n_high        = '0;
                    n_flag        = '0;
                    n_pairs       = '0;
                    n_held        = '0;
                    n_phase       = PH_HIGH;
                    n_end         = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_HIGH;
            r_plain_count <= '0;
            r_out_pos     <= '0;
            r_high        <= '0;
            r_flag        <= '0;
            r_pairs       <= '0;
            r_held        <= '0;
            r_end         <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_plain_count <= n_plain_count;
            r_out_pos     <= n_out_pos;
            r_high        <= n_high;
            r_flag        <= n_flag;
            r_pairs       <= n_pairs;
            r_held        <= n_held;
            r_end         <= n_end;
            r_o_valid     <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_run_cnt  <= n_run_cnt;
        r_run_corr <= n_run_corr;
        r_corr     <= n_corr;
        r_o_char   <= n_o_char;
        r_o_idx    <= n_o_idx;
        r_o_last   <= n_o_last;
    end

    // Drive the channels
    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_o_valid;
    assign o_out.char_value = r_o_char;
    assign o_out.char_index = r_o_idx;
    assign o_out.last       = r_o_last;

endmodule

`default_nettype wire
